// ===== rtl/lru_key_value_cache_defines.svh =====
// Assertion macros used by the LRU key-value cache top level.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define LRUKV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define LRUKV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lrukv_pkg.sv =====
// Package for the LRU key-value cache: opcodes, entry type, widths, reset values.
// No dependencies; used by lrukv_cell and lru_key_value_cache.
`default_nettype none

package lrukv_pkg;

    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int CFG_W     = 5;
    localparam int ENTRIES_DEFAULT = 16;

    localparam logic [CFG_W-1:0]   CAPACITY_RESET = 5'd16;
    localparam logic [VALUE_W-1:0] MISS_VALUE     = '1;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } opcode_t;

    // One cache entry as it moves down the chain
    typedef struct packed {
        logic                      valid;
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/lrukv_cell.sv =====
// One slot of the recency-ordered chain: holds an entry and compares its key.
// Depends on lrukv_pkg. Position in the chain is the entry's recency rank.
`default_nettype none

module lrukv_cell (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                shift_en,   // take the upstream entry
    input  wire lrukv_pkg::entry_t                   prev_entry, // neighbor toward MRU
    input  wire logic signed [lrukv_pkg::KEY_W-1:0]  req_key,
    output lrukv_pkg::entry_t                        entry,
    output logic                                     match
);

    logic                                    valid_reg;
    logic signed [lrukv_pkg::KEY_W-1:0]      key_reg;
    logic signed [lrukv_pkg::VALUE_W-1:0]    value_reg;

    // Valid bit is control state and resets; key and value are payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= prev_entry.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            key_reg   <= prev_entry.key;
            value_reg <= prev_entry.value;
        end
    end

    // Key compare against the request in flight
    assign match = valid_reg && (key_reg == req_key);

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

endmodule

`default_nettype wire

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: request register, cell chain, result register.
// Depends on lrukv_pkg, lrukv_cell and lru_key_value_cache_defines.svh.
//
// Usage:
//   s_ channel carries requests: s_tuser is the opcode (get or put), s_tdata
//   holds the key and the value to store. A get returns one m_ transaction
//   with m_tuser = hit and m_tdata = stored value (all ones on a miss); a put
//   returns nothing. cfg_ writes the capacity (0 acts as 1, values above
//   ENTRIES act as ENTRIES); it is always ready and must only be written idle.
//   Entries live in a chain of cells ordered by recency, most recent at cell 0.
//   A hit or an insert shifts the cells in front of the affected slot down by
//   one and loads the entry into cell 0, so eviction drops the last valid cell.
//   Path: a get sits in the request register, then its result is registered in
//   the result register, which drives m_tvalid.
//   Throughput: one request per cycle while m_ is not stalled; the key compare,
//   shift decision and chain shift all complete in the request register's cycle.
//   A stalled m_ side holds the result; a following get then waits in the
//   request register and s_tready drops, puts pass while that slot is free.
//   Reset clears all valid bits, the occupancy count and both channel stages;
//   capacity returns to 16. No clearing pass is needed.
`default_nettype none
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache #(
    parameter int ENTRIES = lrukv_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // request channel
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [lrukv_pkg::KEY_W+lrukv_pkg::VALUE_W-1:0] s_tdata, // lookup_key, store_value
    input  wire logic                                 s_tuser,  // opcode
    // result channel
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [lrukv_pkg::VALUE_W-1:0]             m_tdata,  // read_value
    output logic                                      m_tuser,  // hit
    // capacity register write
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [lrukv_pkg::CFG_W-1:0]          cfg_data
);

    localparam int OW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (OW > lrukv_pkg::CFG_W) ? OW : lrukv_pkg::CFG_W;

    // Request register
    logic                                    req_valid_reg;
    lrukv_pkg::opcode_t                      req_op_reg;
    logic signed [lrukv_pkg::KEY_W-1:0]      req_key_reg;
    logic signed [lrukv_pkg::VALUE_W-1:0]    req_value_reg;

    // Result register
    logic                                    m_tvalid_reg;
    logic                                    m_hit_reg;
    logic [lrukv_pkg::VALUE_W-1:0]           m_value_reg;

    logic [lrukv_pkg::CFG_W-1:0]             capacity_reg;
    logic [OW-1:0]                           occupancy_reg;
    logic [OW-1:0]                           occupancy_next;

    logic                                    s_accept;
    logic                                    req_done;
    logic                                    any_hit;
    logic                                    insert_free;
    logic [lrukv_pkg::CFG_W-1:0]             cap_eff;
    logic signed [lrukv_pkg::VALUE_W-1:0]    hit_value;
    lrukv_pkg::entry_t                       head_entry;
    lrukv_pkg::entry_t                       cell_entry [ENTRIES];
    logic [ENTRIES-1:0]                      match_vec;
    logic [ENTRIES-1:0]                      valid_vec;
    logic [ENTRIES-1:0]                      shift_en;

    // Handshakes
    assign req_done  = req_valid_reg &&
                       !((req_op_reg == lrukv_pkg::OP_GET) && m_tvalid_reg && !m_tready);
    assign s_tready  = !req_valid_reg || req_done;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_tready) begin
            req_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_op_reg    <= lrukv_pkg::opcode_t'(s_tuser);
            req_key_reg   <= s_tdata[lrukv_pkg::KEY_W-1:0];
            req_value_reg <= s_tdata[lrukv_pkg::KEY_W+lrukv_pkg::VALUE_W-1:lrukv_pkg::KEY_W];
        end
    end

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lrukv_pkg::CAPACITY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            capacity_reg <= cfg_data;
        end
    end

    // Hit detection and hit value select
    assign any_hit = |match_vec;

    always_comb begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match_vec[i]) begin
                hit_value = hit_value | cell_entry[i].value;
            end
        end
    end

    // Free slot available: below capacity and below chain length
    assign cap_eff     = (capacity_reg == '0) ? lrukv_pkg::CFG_W'(1) : capacity_reg;
    assign insert_free = (CMPW'(occupancy_reg) < CMPW'(cap_eff)) &&
                         (occupancy_reg != OW'(ENTRIES));

    // Entry loaded into the most-recent cell
    assign head_entry.valid = 1'b1;
    assign head_entry.key   = req_key_reg;
    assign head_entry.value = (req_op_reg == lrukv_pkg::OP_GET) ? hit_value : req_value_reg;

    // Cell chain with per-cell shift decision
    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            logic hit_shift;
            logic ins_shift;
            lrukv_pkg::entry_t prev_entry;

            // Cells up to and including the hit slot move down by one
            assign hit_shift = |match_vec[ENTRIES-1:gi];
            // Insert: shift into the free slot, or drop the last valid cell
            assign ins_shift = insert_free ? (OW'(gi) <= occupancy_reg)
                                           : (OW'(gi) <  occupancy_reg);

            assign shift_en[gi] = req_done &&
                                  (any_hit ? hit_shift
                                           : ((req_op_reg == lrukv_pkg::OP_PUT) && ins_shift));

            if (gi == 0) begin : g_head
                assign prev_entry = head_entry;
            end else begin : g_body
                assign prev_entry = cell_entry[gi-1];
            end

            lrukv_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .shift_en   (shift_en[gi]),
                .prev_entry (prev_entry),
                .req_key    (req_key_reg),
                .entry      (cell_entry[gi]),
                .match      (match_vec[gi])
            );

            assign valid_vec[gi] = cell_entry[gi].valid;
        end
    endgenerate

    // Occupancy grows only on an insert into a free slot
    always_comb begin
        occupancy_next = occupancy_reg;
        if (req_done && (req_op_reg == lrukv_pkg::OP_PUT) && !any_hit && insert_free) begin
            occupancy_next = occupancy_reg + OW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occupancy_reg <= '0;
        end else begin
            occupancy_reg <= occupancy_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (req_done && (req_op_reg == lrukv_pkg::OP_GET)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_done && (req_op_reg == lrukv_pkg::OP_GET)) begin
            m_hit_reg   <= any_hit;
            m_value_reg <= any_hit ? hit_value : lrukv_pkg::MISS_VALUE;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = m_value_reg;

    // Checks
    `LRUKV_ASSERT_NOW(a_match_unique, req_valid_reg, $onehot0(match_vec),
        "more than one cell matches the request key")
    `LRUKV_ASSERT_NOW(a_occupancy_count, 1'b1, $countones(valid_vec) == int'(occupancy_reg),
        "occupancy count differs from number of valid cells")
    `LRUKV_ASSERT_NOW(a_valid_packed, 1'b1, (valid_vec & (valid_vec + ENTRIES'(1))) == '0,
        "valid cells are not packed toward the most recent end")
    `LRUKV_ASSERT_NEXT(a_get_result, req_done && (req_op_reg == lrukv_pkg::OP_GET),
        m_tvalid, "completed get did not produce a result")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for lru_key_value_cache: directed table, then random get/put traffic.
// Depends on lrukv_pkg and the lru_key_value_cache RTL; a built-in LRU predictor checks each untyped read.
`timescale 1ns / 100ps

module testbench;

    localparam int SLOTS       = lrukv_pkg::ENTRIES_DEFAULT;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    localparam logic [31:0] MISS_RV = lrukv_pkg::MISS_VALUE;

    typedef enum logic [1:0] {
        ROW_PREDICT,  // result (if any) checked against the predictor
        ROW_TYPED,    // result typed into the table
        ROW_CAPACITY  // capacity write, val holds the setting
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        lrukv_pkg::opcode_t op;
        logic [31:0]        key;
        logic [31:0]        val;
        logic               hit;
        logic [31:0]        rv;
    } dir_row_t;

    typedef struct {
        logic        hit;
        logic [31:0] value;
    } read_result_t;

    // Directed rows: extremes, update, miss value collision, capacity corner cases
    localparam int NUM_DIRECTED = 26;
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        '{ROW_TYPED,    lrukv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, MISS_RV},
        '{ROW_TYPED,    lrukv_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, MISS_RV},
        '{ROW_PREDICT,  lrukv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{ROW_TYPED,    lrukv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
        '{ROW_PREDICT,  lrukv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0},
        '{ROW_TYPED,    lrukv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h8000_0000},
        '{ROW_PREDICT,  lrukv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{ROW_TYPED,    lrukv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        '{ROW_PREDICT,  lrukv_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
        '{ROW_TYPED,    lrukv_pkg::OP_GET, 32'h0000_0000, 32'h5555_AAAA, 1'b1, 32'h0000_0000},
        '{ROW_PREDICT,  lrukv_pkg::OP_PUT, 32'h8000_0000, 32'h0000_1234, 1'b0, 32'h0},
        '{ROW_TYPED,    lrukv_pkg::OP_GET, 32'h8000_0000, 32'hDEAD_BEEF, 1'b1, 32'h0000_1234},
        '{ROW_TYPED,    lrukv_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, MISS_RV},
        // lower capacity below occupancy: inserts evict, nothing dropped
        '{ROW_CAPACITY, lrukv_pkg::OP_GET, 32'h0,         32'd1,         1'b0, 32'h0},
        '{ROW_PREDICT,  lrukv_pkg::OP_PUT, 32'h0000_0005, 32'h0000_0055, 1'b0, 32'h0},
        '{ROW_PREDICT,  lrukv_pkg::OP_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, 32'h0},
        '{ROW_PREDICT,  lrukv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0},
        '{ROW_PREDICT,  lrukv_pkg::OP_PUT, 32'h0000_0006, 32'h0000_0066, 1'b0, 32'h0},
        '{ROW_PREDICT,  lrukv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
        // zero capacity acts as one
        '{ROW_CAPACITY, lrukv_pkg::OP_GET, 32'h0,         32'd0,         1'b0, 32'h0},
        '{ROW_PREDICT,  lrukv_pkg::OP_PUT, 32'h0000_0007, 32'h0000_0077, 1'b0, 32'h0},
        '{ROW_PREDICT,  lrukv_pkg::OP_GET, 32'h0000_0006, 32'h0000_0000, 1'b0, 32'h0},
        // above the entry count saturates
        '{ROW_CAPACITY, lrukv_pkg::OP_GET, 32'h0,         32'd31,        1'b0, 32'h0},
        '{ROW_PREDICT,  lrukv_pkg::OP_PUT, 32'h0000_0008, 32'h0000_0088, 1'b0, 32'h0},
        '{ROW_PREDICT,  lrukv_pkg::OP_GET, 32'h0000_0007, 32'h0000_0000, 1'b0, 32'h0},
        '{ROW_PREDICT,  lrukv_pkg::OP_GET, 32'h0000_0008, 32'h0000_0000, 1'b0, 32'h0}
    };

    // Random phases: capacity setting per phase; idle mode follows phase % 4
    logic [4:0] phase_capacity [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd3, 5'd12};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // lookup_key [31:0], store_value [63:32]
    logic        s_tuser = lrukv_pkg::OP_GET; // opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // read_value
    logic        m_tuser;        // hit
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;

    // Predictor state
    logic [31:0] slot_key   [SLOTS];
    logic [31:0] slot_value [SLOTS];
    logic        slot_valid [SLOTS];
    logic [3:0]  slot_rank  [SLOTS];
    logic [4:0]  slot_count = '0;
    logic [4:0]  capacity_reg = lrukv_pkg::CAPACITY_RESET;

    read_result_t pending_reads [$];
    logic [31:0]  key_pool [$];

    int mismatch_count  = 0;
    int reads_checked   = 0;
    int hits_seen       = 0;
    int evictions       = 0;
    int requests_sent   = 0;
    int capacity_writes = 0;
    int cycle_count     = 0;
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    bit hold_req        = 1'b0;
    int hold_left       = 0;

    lru_key_value_cache dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reads outstanding",
                     cycle_count, pending_reads.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stalls plus a long hold-off counted here
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Makes a slot most recent; slots ranked ahead of it move back one
    function automatic void promote_slot(input int slot);
        logic [3:0] r;
        r = slot_rank[slot];
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && i != slot && slot_rank[i] < r)
                slot_rank[i]++;
        slot_rank[slot] = '0;
    endfunction

    // Applies one request to the predicted cache; returns 1 when a read result is due
    function automatic bit access_cache(input lrukv_pkg::opcode_t op,
                                        input logic [31:0] key,
                                        input logic [31:0] val, output read_result_t res);
        int         slot;
        int         oldest;
        logic [4:0] limit;
        slot = -1;
        res.hit   = 1'b0;
        res.value = MISS_RV;
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_key[i] == key && slot < 0)
                slot = i;

        if (op == lrukv_pkg::OP_GET) begin
            if (slot >= 0) begin
                res.hit   = 1'b1;
                res.value = slot_value[slot];
                promote_slot(slot);
            end
            return 1'b1;
        end

        if (slot >= 0) begin
            slot_value[slot] = val;
            promote_slot(slot);
            return 1'b0;
        end

        // New key: free slot while under capacity, else evict the oldest
        limit = (capacity_reg == 0) ? 5'd1 : (capacity_reg > SLOTS) ? 5'(SLOTS) : capacity_reg;
        if (slot_count < limit)
            for (int i = 0; i < SLOTS; i++)
                if (!slot_valid[i] && slot < 0)
                    slot = i;
        if (slot >= 0) begin
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i])
                    slot_rank[i]++;
            slot_valid[slot] = 1'b1;
            slot_rank[slot]  = '0;
            slot_count++;
        end else begin
            oldest = -1;
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && (oldest < 0 || slot_rank[i] > slot_rank[oldest]))
                    oldest = i;
            slot = oldest;
            promote_slot(slot);
            evictions++;
        end
        slot_key[slot]   = key;
        slot_value[slot] = val;
        return 1'b0;
    endfunction

    // Offers one request and waits for its transaction; typed rows override the prediction
    task automatic send_request(input lrukv_pkg::opcode_t op, input logic [31:0] key,
                                input logic [31:0] val, input bit typed,
                                input logic want_hit, input logic [31:0] want_rv);
        read_result_t res;
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, key};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        if (access_cache(op, key, val, res)) begin
            if (typed) begin
                res.hit   = want_hit;
                res.value = want_rv;
            end
            pending_reads.push_back(res);
        end
    endtask

    // Stops offering and waits until every read has returned and puts have settled
    task automatic drain_cache;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [4:0] setting);
        drain_cache();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= setting;
        do @(posedge aclk); while (!cfg_ready);
        capacity_reg = setting;
        capacity_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input read_result_t want);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] %s: expected hit=%0b value=%h, got hit=%0b value=%h",
                     $realtime, what, want.hit, want.value, m_tuser, m_tdata);
    endtask

    // Result checker
    always @(posedge aclk) begin : check_reads
        read_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reads.size() == 0) begin
                want.hit   = 1'bx;
                want.value = 'x;
                note_mismatch("unexpected read result", want);
            end else begin
                want = pending_reads.pop_front();
                reads_checked++;
                if (m_tuser) hits_seen++;
                if (m_tuser !== want.hit || m_tdata !== want.value)
                    note_mismatch("read mismatch", want);
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        int                 pool_size;
        logic [31:0]        key;
        lrukv_pkg::opcode_t op;
        for (int i = 0; i < SLOTS; i++) begin
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_valid[i] = 1'b0;
            slot_rank[i]  = '0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table, reset capacity first
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            if (directed_rows[r].kind == ROW_CAPACITY)
                write_capacity(directed_rows[r].val[4:0]);
            else
                send_request(directed_rows[r].op, directed_rows[r].key, directed_rows[r].val,
                             directed_rows[r].kind == ROW_TYPED,
                             directed_rows[r].hit, directed_rows[r].rv);
        end

        // Random phases
        for (int p = 0; p < PHASES; p++) begin
            write_capacity(phase_capacity[p]);
            case (p % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 79; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 79; end
                default: begin sender_idle_pct = 19; stall_pct = 19; end
            endcase

            // Key pool a little larger than the capacity gives hits and evictions
            pool_size = SLOTS + 4;
            if (phase_capacity[p] != 0 && phase_capacity[p] < SLOTS)
                pool_size = phase_capacity[p] + 2 + $urandom_range(3);
            key_pool.delete();
            for (int k = 0; k < pool_size; k++) begin
                case ($urandom_range(9))
                    0: key = 32'h8000_0000;
                    1: key = 32'h7FFF_FFFF;
                    2: key = 32'hFFFF_FFFF;
                    default: key = $urandom;
                endcase
                key_pool.push_back(key);
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Long receiver hold-off while requests keep coming
                if (p == 0 && n == 60)
                    hold_req = 1'b1;
                // Sender pause until the pipeline is empty
                if (p == 4 && n == 100)
                    drain_cache();
                op  = lrukv_pkg::opcode_t'($urandom_range(1));
                key = ($urandom_range(15) == 0) ? 32'($urandom)
                                                : key_pool[$urandom_range(pool_size - 1)];
                send_request(op, key, $urandom, 1'b0, 1'b0, '0);
            end
        end

        drain_cache();
        repeat (SETTLE) @(posedge aclk);
        $display("Ran %0d requests over %0d capacity settings:", requests_sent, capacity_writes);
        $display("  %0d reads checked, %0d hits, %0d evictions",
                 reads_checked, hits_seen, evictions);
        $display("Mismatches: %0d, reads outstanding: %0d", mismatch_count, pending_reads.size());
        if (mismatch_count == 0 && pending_reads.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
